// ===== rtl/core/page_frame_allocator_top_assert.svh =====
// ----------------------------------------------------------------------------
// page frame allocator assertion macros
// shared property forms for the allocator's concurrent checks
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("page frame allocator check failed");

// next-cycle implication, checked outside reset
`define PFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("page frame allocator check failed");

`endif

// ===== rtl/core/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// shared types and constants of the page frame allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int FRAME_BITS   = 40;
  localparam int SUM_BITS     = FRAME_BITS + 2;
  localparam int CFG_IDX_BITS = 3;
  localparam int REG_SEL_BITS = 2;

  localparam int FREE_DEPTH_DEF  = 1024;
  localparam int NUM_REGIONS_DEF = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_COUNT  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REGION0_START = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REGION2_END   = 3'd6;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } pfa_cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_OOM  = 2'd1,
    STATUS_FULL = 2'd2
  } pfa_status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } pfa_state_e;

  // bump allocation view of the regions
  typedef struct packed {
    logic                  found;
    logic [FRAME_BITS-1:0] frame;
    logic [SUM_BITS-1:0]   untouched_now;
    logic [SUM_BITS-1:0]   untouched_taken;
  } pfa_bump_t;

endpackage

// ===== rtl/core/pfa_stack_mem.sv =====
// ----------------------------------------------------------------------------
// pfa_stack_mem
// free stack storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module pfa_stack_mem #(
  parameter int DEPTH = pfa_pkg::FREE_DEPTH_DEF,
  parameter int WIDTH = pfa_pkg::FRAME_BITS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/pfa_regions.sv =====
// ----------------------------------------------------------------------------
// pfa_regions
// region registers, bump counters and registered frames-left per region
// ----------------------------------------------------------------------------
module pfa_regions #(
  parameter int NUM_REGIONS = pfa_pkg::NUM_REGIONS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pfa_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [pfa_pkg::FRAME_BITS-1:0]    cfg_data_i,
  input  logic                              bump_i,
  output pfa_pkg::pfa_bump_t                info_o
);

  localparam int FB = pfa_pkg::FRAME_BITS;
  localparam int SB = pfa_pkg::SUM_BITS;
  localparam int RB = pfa_pkg::REG_SEL_BITS;

  logic [RB-1:0]                       count_q;
  logic [NUM_REGIONS-1:0][FB-1:0]      left_all;
  logic [NUM_REGIONS-1:0][FB-1:0]      next_all;
  logic [NUM_REGIONS-1:0]              wr_start;
  logic [NUM_REGIONS-1:0]              wr_end;
  logic [pfa_pkg::CFG_IDX_BITS-1:0]    cfg_off;
  logic                                cfg_in_range;
  logic [RB-1:0]                       sel;
  logic                                found;
  logic [FB-1:0]                       frame;
  logic [SB-1:0]                       sum;

  // regions occupy indexes in start/end pairs
  always_comb begin
    cfg_off      = cfg_idx_i - pfa_pkg::CFG_REGION0_START;
    cfg_in_range = (cfg_idx_i >= pfa_pkg::CFG_REGION0_START) &&
                   (cfg_idx_i <= pfa_pkg::CFG_REGION2_END);
    for (int r = 0; r < NUM_REGIONS; r++) begin
      wr_start[r] = cfg_we_i && cfg_in_range && !cfg_off[0] &&
                    (cfg_off[RB:1] == RB'(r));
      wr_end[r]   = cfg_we_i && cfg_in_range && cfg_off[0] &&
                    (cfg_off[RB:1] == RB'(r));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == pfa_pkg::CFG_REGION_COUNT)) begin
      count_q <= cfg_data_i[RB-1:0];
    end
  end

  for (genvar r = 0; r < NUM_REGIONS; r++) begin : g_region
    logic [FB-1:0] start_q, end_q, used_q, left_q, next_q;
    logic [FB:0]   nxt;
    logic          active;

    assign nxt    = {1'b0, start_q} + {1'b0, used_q};
    assign active = RB'(r) < count_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        start_q <= '0;
        end_q   <= '0;
        used_q  <= '0;
        left_q  <= '0;
        next_q  <= '0;
      end else begin
        if (wr_start[r]) begin
          start_q <= cfg_data_i;
        end
        if (wr_end[r]) begin
          end_q <= cfg_data_i;
        end
        if (bump_i && (sel == RB'(r))) begin
          used_q <= used_q + FB'(1);
        end
        next_q <= nxt[FB-1:0];
        // an exhausted or inactive region counts zero
        left_q <= (active && (nxt < {1'b0, end_q})) ? (end_q - nxt[FB-1:0]) : '0;
      end
    end

    assign left_all[r] = left_q;
    assign next_all[r] = next_q;
  end

  always_comb begin
    found = 1'b0;
    sel   = '0;
    frame = '0;
    sum   = '0;
    for (int r = 0; r < NUM_REGIONS; r++) begin
      if (!found && (left_all[r] != '0)) begin
        found = 1'b1;
        sel   = RB'(r);
        frame = next_all[r];
      end
      sum = sum + SB'(left_all[r]);
    end
  end

  assign info_o.found           = found;
  assign info_o.frame           = frame;
  assign info_o.untouched_now   = sum;
  assign info_o.untouched_taken = sum - SB'(1);

endmodule

// ===== rtl/core/page_frame_allocator_top.sv =====
// ----------------------------------------------------------------------------
// page_frame_allocator_top
// frame number allocator: lifo free stack in front of bump regions
// ----------------------------------------------------------------------------
// requests enter on the s_axis channel: tuser is the command (0 allocate,
// 1 free), tdata the frame to free. each request gives one response on
// m_axis with the allocated frame, a status and the untouched frame count.
// configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
// no request is in flight; a request is not taken in the cycle of a write.
// a request is accepted in idle, where the top of the free stack is read from
// the registered-read stack memory; in the execute state it then updates the
// stack or region and loads the response register, which drives m_axis.
// a new request is not taken until the current one leaves the execute state.
// the response register lets the next request enter while a response waits;
// if m_axis_tready stays low, that request holds in its execute state until
// the register frees up.
// reset empties the stack, clears all region registers and counters and
// drops any pending response; the stack memory itself is not cleared.
// ----------------------------------------------------------------------------
`include "page_frame_allocator_top_assert.svh"

module page_frame_allocator_top #(
  parameter int FREE_DEPTH  = pfa_pkg::FREE_DEPTH_DEF,
  parameter int NUM_REGIONS = pfa_pkg::NUM_REGIONS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [pfa_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [pfa_pkg::FRAME_BITS-1:0]    cfg_data_i,
  // request channel
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [39:0]                       s_axis_tdata,   // frame_in
  input  logic                              s_axis_tuser,   // command
  // response channel
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [87:0]                       m_axis_tdata    // frame_out, status,
                                                            // untouched_frames, pad
);

  localparam int FB = pfa_pkg::FRAME_BITS;
  localparam int SB = pfa_pkg::SUM_BITS;
  localparam int AW = $clog2(FREE_DEPTH);
  localparam int CW = $clog2(FREE_DEPTH + 1);
  localparam int OW = FB + 2 + SB;

  pfa_pkg::pfa_state_e  state_q, state_d;
  pfa_pkg::pfa_cmd_e    cmd_q;
  logic [FB-1:0]        frame_in_q;
  logic [CW-1:0]        count_q, count_d;
  logic                 out_valid_q;
  logic [OW-1:0]        out_data_q;

  logic                 accept;
  logic                 commit;
  logic                 stack_full;
  logic                 push, pop, bump;
  logic [FB-1:0]        rd_frame;
  logic [FB-1:0]        frame_out;
  pfa_pkg::pfa_status_e status;
  logic [SB-1:0]        untouched;
  pfa_pkg::pfa_bump_t   bump_info;

  assign s_axis_tready = (state_q == pfa_pkg::ST_IDLE) && !cfg_we_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == pfa_pkg::ST_EXEC) && (!out_valid_q || m_axis_tready);
  assign stack_full    = count_q == CW'(FREE_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfa_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = pfa_pkg::ST_EXEC;
        end
      end
      pfa_pkg::ST_EXEC: begin
        if (commit) begin
          state_d = pfa_pkg::ST_IDLE;
        end
      end
      default: state_d = pfa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= pfa_pkg::pfa_cmd_e'(s_axis_tuser);
      frame_in_q <= s_axis_tdata[FB-1:0];
    end
  end

  // decide what the request does once the stack top is available
  always_comb begin
    push      = 1'b0;
    pop       = 1'b0;
    bump      = 1'b0;
    frame_out = '0;
    status    = pfa_pkg::STATUS_OK;
    untouched = bump_info.untouched_now;
    priority if (cmd_q == pfa_pkg::CMD_FREE) begin
      if (stack_full) begin
        status = pfa_pkg::STATUS_FULL;
      end else begin
        push = commit;
      end
    end else if (count_q != '0) begin
      pop       = commit;
      frame_out = rd_frame;
    end else if (bump_info.found) begin
      bump      = commit;
      frame_out = bump_info.frame;
      untouched = bump_info.untouched_taken;
    end else begin
      status = pfa_pkg::STATUS_OOM;
    end
  end

  always_comb begin
    count_d = count_q;
    if (push) begin
      count_d = count_q + CW'(1);
    end else if (pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= {untouched, status, frame_out};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(88 - OW)'(0), out_data_q};

  pfa_stack_mem #(
    .DEPTH (FREE_DEPTH),
    .WIDTH (FB),
    .AW    (AW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (frame_in_q),
    .re_i    (accept),
    .raddr_i (AW'(count_q - CW'(1))),
    .rdata_o (rd_frame)
  );

  pfa_regions #(
    .NUM_REGIONS (NUM_REGIONS)
  ) u_regions (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .bump_i     (bump),
    .info_o     (bump_info)
  );

  `PFA_ASSERT_NEXT(a_one_request_in_flight, accept, !s_axis_tready)
  `PFA_ASSERT_NOW(a_count_in_range, 1'b1, count_q <= CW'(FREE_DEPTH))
  `PFA_ASSERT_NOW(a_refuse_only_when_full,
                  commit && (status == pfa_pkg::STATUS_FULL), stack_full)
  `PFA_ASSERT_NOW(a_no_response_overwrite, commit, !out_valid_q || m_axis_tready)

endmodule
